[hw/rtl/ceeq_pkg.sv]
// ----------------------------------------------------------------------------
// ceeq_pkg
// Shared types and constants for the coalescing expiring egress queue.
// ----------------------------------------------------------------------------
package ceeq_pkg;

  localparam int QUEUE_DEPTH    = 256;
  localparam int RELIABLE_LIMIT = 64;
  localparam int IDX_W          = $clog2(QUEUE_DEPTH);
  localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_ENQ   = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_INVAL = 2'd2;

  localparam logic [2:0] REASON_NONE         = 3'd0;
  localparam logic [2:0] REASON_BACKPRESSURE = 3'd1;

  typedef struct packed {
    logic        lane;
    logic [15:0] msg_id;
    logic [47:0] sequence_no;
    logic [47:0] tick;
    logic [47:0] expires;
    logic [15:0] handle;
    logic [15:0] length;
  } entry_t;

endpackage

[hw/rtl/ceeq_ram.sv]
// ----------------------------------------------------------------------------
// ceeq_ram
// Single write port, single registered read port entry memory.
// ----------------------------------------------------------------------------
module ceeq_ram
  import ceeq_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/coalescing_expiring_egress_queue.sv]
// ----------------------------------------------------------------------------
// coalescing_expiring_egress_queue
// Two-lane egress descriptor ring with replace scan and expiry on pop.
// ----------------------------------------------------------------------------
// One transfer at a time is processed. An invalidate, an unused mode or a step
// that is rejected at once goes from the idle state straight to the done state,
// a plain enqueue through the enqueue state first. An enqueue with
// replace_same_id scans the ring through the single read port of the entry
// memory, reading each queued entry and writing back those it keeps, before
// it enqueues. A pop reads and drops head entries, expired entries included,
// until it returns one that has not expired or runs out of entries. The
// result register is loaded at the end and the next input transfer may be
// taken while it waits to be taken.
module coalescing_expiring_egress_queue
  import ceeq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic        in_lane,
  input  logic [15:0] in_message_id,
  input  logic [47:0] in_app_sequence,
  input  logic [47:0] in_app_tick,
  input  logic [47:0] in_expires_at,
  input  logic [15:0] in_payload_handle,
  input  logic [15:0] in_payload_length,
  input  logic        in_replace_same_id,
  input  logic        in_budget_ok,
  input  logic [47:0] in_now_ms,
  input  logic [2:0]  in_reason_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic        out_out_lane,
  output logic [15:0] out_out_message_id,
  output logic [47:0] out_out_sequence,
  output logic [47:0] out_out_tick,
  output logic [47:0] out_out_expires_at,
  output logic [15:0] out_out_payload_handle,
  output logic [15:0] out_out_payload_length,
  output logic [8:0]  out_released_count,
  output logic [8:0]  out_queued_count,
  output logic [8:0]  out_reliable_count,
  output logic [2:0]  out_session_reason
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_WB, S_ENQ, S_POP_RD, S_POP_CHK, S_DONE
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  head_r;
  logic [CNT_W-1:0]  count_r, rel_r, scan_i_r, scan_w_r, released_r;
  logic [2:0]        reason_r;
  entry_t            new_r;
  logic              budget_r;
  logic [47:0]       now_r;
  logic              res_ok_r;
  entry_t            res_e_r;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  entry_t            wdata, rdata;

  ceeq_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state_r != S_IDLE);

  logic in_take;
  assign in_take = in_valid && !in_stall;

  logic match;
  assign match = (rdata.lane == 1'b0) && (rdata.msg_id == new_r.msg_id);

  logic in_enq_ok;
  assign in_enq_ok = !(count_r >= CNT_W'(QUEUE_DEPTH)) &&
                     !(new_r.lane && rel_r >= CNT_W'(RELIABLE_LIMIT)) && budget_r;

  // Read address follows the state that launches the read.
  always_comb begin
    raddr = head_r;
    if (state_r == S_SCAN_RD) begin
      raddr = head_r + scan_i_r[IDX_W-1:0];
    end
    we    = 1'b0;
    waddr = head_r + scan_w_r[IDX_W-1:0];
    wdata = rdata;
    if (state_r == S_SCAN_WB && !match) begin
      we = 1'b1;
    end else if (state_r == S_ENQ && in_enq_ok) begin
      we    = 1'b1;
      waddr = head_r + count_r[IDX_W-1:0];
      wdata = new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      count_r    <= '0;
      rel_r      <= '0;
      reason_r   <= REASON_NONE;
      out_valid  <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            new_r      <= '{in_lane, in_message_id, in_app_sequence, in_app_tick,
                            in_expires_at, in_payload_handle, in_payload_length};
            budget_r   <= in_budget_ok;
            now_r      <= in_now_ms;
            released_r <= '0;
            res_ok_r   <= 1'b0;
            res_e_r    <= '0;
            scan_i_r   <= '0;
            scan_w_r   <= '0;
            case (in_mode)
              MODE_ENQ: begin
                if (reason_r == REASON_NONE && in_payload_length != 16'd0) begin
                  state_r <= in_replace_same_id ? S_SCAN_RD : S_ENQ;
                end else begin
                  state_r <= S_DONE;
                end
              end
              MODE_POP: begin
                if (reason_r == REASON_NONE && in_now_ms != 48'd0) begin
                  state_r <= S_POP_RD;
                end else begin
                  state_r <= S_DONE;
                end
              end
              MODE_INVAL: begin
                if (reason_r == REASON_NONE) begin
                  reason_r <= in_reason_code;
                end
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN_RD: begin
          state_r <= (scan_i_r < count_r) ? S_SCAN_WB : S_ENQ;
          if (scan_i_r >= count_r) begin
            count_r <= scan_w_r;
          end
        end
        S_SCAN_WB: begin
          if (match) begin
            released_r <= released_r + 1'b1;
          end else begin
            scan_w_r <= scan_w_r + 1'b1;
          end
          scan_i_r <= scan_i_r + 1'b1;
          state_r  <= S_SCAN_RD;
        end
        S_ENQ: begin
          if (in_enq_ok) begin
            count_r  <= count_r + 1'b1;
            rel_r    <= rel_r + CNT_W'(new_r.lane);
            res_ok_r <= 1'b1;
          end else if (reason_r == REASON_NONE) begin
            reason_r <= REASON_BACKPRESSURE;
          end
          state_r <= S_DONE;
        end
        S_POP_RD: begin
          state_r <= (count_r != '0) ? S_POP_CHK : S_DONE;
        end
        S_POP_CHK: begin
          head_r     <= head_r + 1'b1;
          count_r    <= count_r - 1'b1;
          released_r <= released_r + 1'b1;
          if (rdata.lane && rel_r != '0) begin
            rel_r <= rel_r - 1'b1;
          end
          if (now_r >= rdata.expires) begin
            state_r <= S_POP_RD;
          end else begin
            res_ok_r <= 1'b1;
            res_e_r  <= rdata;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_ok                 <= res_ok_r;
            out_out_lane           <= res_e_r.lane;
            out_out_message_id     <= res_e_r.msg_id;
            out_out_sequence       <= res_e_r.sequence_no;
            out_out_tick           <= res_e_r.tick;
            out_out_expires_at     <= res_e_r.expires;
            out_out_payload_handle <= res_e_r.handle;
            out_out_payload_length <= res_e_r.length;
            out_released_count     <= 9'(released_r);
            out_queued_count       <= 9'(count_r);
            out_reliable_count     <= 9'(rel_r);
            out_session_reason     <= reason_r;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The queue never holds more entries than it has room for.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond depth");
  // Reliable entries are a subset of all entries.
  assert property (@(posedge clk) disable iff (!rst_n) rel_r <= count_r)
    else $error("reliable count exceeds entry count");
  // Once set, the session reason never returns to active.
  assert property (@(posedge clk) disable iff (!rst_n)
    reason_r != REASON_NONE |=> reason_r == $past(reason_r))
    else $error("session reason changed after invalidation");
  // The compaction write pointer never passes the read pointer.
  assert property (@(posedge clk) disable iff (!rst_n) scan_w_r <= scan_i_r || state_r == S_IDLE)
    else $error("compaction overtook scan");

endmodule
